// ===== rtl/core/bitmap_page_frame_allocator_core_assert.svh =====
// Assertion macros used by the page frame allocator core.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define BPFA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpfa assertion failed");

`define BPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpfa assertion failed");

`else

`define BPFA_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define BPFA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/bpfa_pkg.sv =====
// Types and constants of the bitmap page frame allocator.
package bpfa_pkg;

   localparam int FUNC_W  = 3;
   localparam int PAGE_W  = 14;
   localparam int IPAGE_W = 15;
   localparam int CNT_W   = 15;
   localparam int STAT_W  = 2;

   localparam logic [FUNC_W-1:0] FUNC_REQUEST   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOCK      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RESERVE   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_UNRESERVE = 3'd4;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE,
      STAT_ALREADY,
      STAT_RANGE,
      STAT_NO_FREE
   } status_type;

   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [IPAGE_W-1:0] ipage_type;

   localparam count_type CNT_MAX     = '1;
   localparam count_type PAGES_RESET = 15'd16384;
   localparam int        IPAGE_SPAN  = 32768;

endpackage

// ===== rtl/core/bitmap_page_frame_allocator_core.sv =====
// Bitmap page frame allocator: one operation per beat on a used-page bitmap held in memory.
// Free, lock, reserve and unreserve: accept, then EVAL, then the registered result strobe.
// A request scans the bitmap word by word from the hint word until a free page or the limit.
// The next beat can be accepted in the cycle that carries the strobe; results cannot be stalled.
// After reset the bitmap memory is cleared one word per cycle (256 words at default size).
// Busy stays high during that pass; configuration writes are taken at any time.
`include "bitmap_page_frame_allocator_core_assert.svh"

module bitmap_page_frame_allocator_core #(
   parameter int NUM_PAGES = 16384,
   parameter int WORD_BITS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [bpfa_pkg::FUNC_W-1:0]     req_func,
   input  logic [bpfa_pkg::PAGE_W-1:0]     req_page_index,
   output logic                            rsp_strobe,
   output logic [bpfa_pkg::PAGE_W-1:0]     rsp_result_page,
   output logic [bpfa_pkg::STAT_W-1:0]     rsp_status,
   output logic [bpfa_pkg::CNT_W-1:0]      rsp_free_pages,
   output logic [bpfa_pkg::CNT_W-1:0]      rsp_used_pages,
   output logic [bpfa_pkg::CNT_W-1:0]      rsp_reserved_pages,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bpfa_pkg::CNT_W-1:0]      csr_pages_in_use
);

   import bpfa_pkg::*;

   localparam int LB_W        = $clog2(WORD_BITS);
   localparam int LANE_BITS   = 1 << LB_W;
   localparam int STORE_PAGES = (NUM_PAGES < IPAGE_SPAN) ? NUM_PAGES : IPAGE_SPAN;
   localparam int MAP_WORDS   = (STORE_PAGES + LANE_BITS - 1) / LANE_BITS;
   localparam int ADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WN_W        = IPAGE_W - LB_W;
   localparam int CAP_PAGES   = (STORE_PAGES < IPAGE_SPAN - 1) ? STORE_PAGES : IPAGE_SPAN - 1;

   localparam ipage_type         NP_CAP   = IPAGE_W'(CAP_PAGES);
   localparam logic [ADDR_W-1:0] CLR_LAST = '1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;
   count_type              csr_pages_ff, csr_pages_in;
   ipage_type              hint_ff, hint_in;
   count_type              used_ff, used_in;
   count_type              rsv_ff, rsv_in;
   logic [FUNC_W-1:0]      func_ff, func_in;
   logic [PAGE_W-1:0]      idx_ff, idx_in;
   ipage_type              limit_ff, limit_in;
   logic [WN_W-1:0]        scan_word_ff, scan_word_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [PAGE_W-1:0]      rsp_page_ff, rsp_page_in;
   status_type             rsp_status_ff, rsp_status_in;

   ipage_type              limit;
   ipage_type              rd_page;
   logic [WN_W-1:0]        rd_word;
   logic                   accept;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [LANE_BITS-1:0]   mem_wdata;
   logic [LANE_BITS-1:0]   rd_data;
   logic                   scan_found;
   logic [LB_W-1:0]        scan_pos;
   logic [LANE_BITS-1:0]   scan_onehot;
   logic [LB_W-1:0]        cur_off;
   logic [LANE_BITS-1:0]   cur_onehot;
   ipage_type              idx_i;
   ipage_type              limit_m1;
   ipage_type              grant_page;
   logic                   want;
   logic                   bad;
   logic                   hint_ok;
   count_type              used_inc, used_dec, rsv_inc, rsv_dec;
   logic [IPAGE_W:0]       taken;

   assign limit   = (csr_pages_ff > NP_CAP) ? NP_CAP : csr_pages_ff;
   assign accept  = start && (state_ff == ST_IDLE);
   assign rd_page = (req_func == FUNC_REQUEST) ? hint_ff : {1'b0, req_page_index};

   always_comb begin
      case (state_ff)
         ST_IDLE: rd_word = rd_page[IPAGE_W-1:LB_W];
         ST_EVAL: rd_word = scan_word_ff + 1'b1;
         default: rd_word = scan_word_ff;
      endcase
   end

   bpfa_map_ram #(
      .WIDTH  (LANE_BITS),
      .ADDR_W (ADDR_W)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (rd_word[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   bpfa_word_scan #(
      .LANE_BITS (LANE_BITS)
   ) u_word_scan (
      .word     (rd_data),
      .word_num (scan_word_ff),
      .hint     (hint_ff),
      .limit    (limit_ff),
      .found    (scan_found),
      .pos      (scan_pos),
      .onehot   (scan_onehot)
   );

   assign cur_off    = idx_ff[LB_W-1:0];
   assign cur_onehot = LANE_BITS'(1) << cur_off;
   assign idx_i      = {1'b0, idx_ff};
   assign limit_m1   = limit_ff - 1'b1;
   assign grant_page = {scan_word_ff, scan_pos};
   assign want       = (func_ff == FUNC_LOCK) || (func_ff == FUNC_RESERVE);
   assign bad        = (func_ff > FUNC_UNRESERVE) || (idx_i >= limit_ff);
   assign hint_ok    = hint_ff < limit_ff;
   assign used_inc   = (used_ff == CNT_MAX) ? used_ff : used_ff + 1'b1;
   assign used_dec   = (used_ff == '0) ? used_ff : used_ff - 1'b1;
   assign rsv_inc    = (rsv_ff == CNT_MAX) ? rsv_ff : rsv_ff + 1'b1;
   assign rsv_dec    = (rsv_ff == '0) ? rsv_ff : rsv_ff - 1'b1;

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      csr_pages_in  = csr_valid ? csr_pages_in_use : csr_pages_ff;
      hint_in       = hint_ff;
      used_in       = used_ff;
      rsv_in        = rsv_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      limit_in      = limit_ff;
      scan_word_in  = scan_word_ff;
      rsp_strobe_in = 1'b0;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = scan_word_ff[ADDR_W-1:0];
      mem_wdata     = rd_data;
      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               func_in      = req_func;
               idx_in       = req_page_index;
               limit_in     = limit;
               scan_word_in = rd_word;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (func_ff == FUNC_REQUEST) begin
               if (!hint_ok) begin
                  rsp_page_in   = '0;
                  rsp_status_in = STAT_NO_FREE;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else if (scan_found) begin
                  mem_we        = 1'b1;
                  mem_wdata     = rd_data | scan_onehot;
                  used_in       = used_inc;
                  hint_in       = grant_page;
                  rsp_page_in   = grant_page[PAGE_W-1:0];
                  rsp_status_in = STAT_DONE;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else if (scan_word_ff == limit_m1[IPAGE_W-1:LB_W]) begin
                  hint_in       = limit_ff;
                  rsp_page_in   = '0;
                  rsp_status_in = STAT_NO_FREE;
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  scan_word_in = scan_word_ff + 1'b1;
               end
            end else begin
               rsp_page_in   = idx_ff;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               if (bad) begin
                  rsp_status_in = STAT_RANGE;
               end else if (rd_data[cur_off] == want) begin
                  rsp_status_in = STAT_ALREADY;
               end else begin
                  rsp_status_in = STAT_DONE;
                  mem_we        = 1'b1;
                  mem_waddr     = idx_ff[LB_W +: ADDR_W];
                  mem_wdata     = want ? (rd_data | cur_onehot) : (rd_data & ~cur_onehot);
                  case (func_ff)
                     FUNC_FREE:    used_in = used_dec;
                     FUNC_LOCK:    used_in = used_inc;
                     FUNC_RESERVE: rsv_in  = rsv_inc;
                     default:      rsv_in  = rsv_dec;
                  endcase
                  if (!want && (hint_ff > idx_i)) begin
                     hint_in = idx_i;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         csr_pages_ff  <= PAGES_RESET;
         hint_ff       <= '0;
         used_ff       <= '0;
         rsv_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         csr_pages_ff  <= csr_pages_in;
         hint_ff       <= hint_in;
         used_ff       <= used_in;
         rsv_ff        <= rsv_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      limit_ff      <= limit_in;
      scan_word_ff  <= scan_word_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign taken = {1'b0, used_ff} + {1'b0, rsv_ff};

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_result_page    = rsp_page_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_used_pages     = used_ff;
   assign rsp_reserved_pages = rsv_ff;
   assign rsp_free_pages     = ({1'b0, limit_ff} > taken) ?
                               CNT_W'({1'b0, limit_ff} - taken) : '0;

   `BPFA_ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe_ff, state_ff == ST_IDLE)
   `BPFA_ASSERT_NEXT(a_accept_eval, clock, reset, accept, state_ff == ST_EVAL)
   `BPFA_ASSERT_NEXT(a_write_ends_beat, clock, reset, mem_we && (state_ff == ST_EVAL), rsp_strobe_ff)
   `BPFA_ASSERT_SAME(a_no_free_zero, clock, reset, rsp_strobe_ff && (rsp_status_ff == STAT_NO_FREE), rsp_page_ff == '0)

endmodule

// ===== rtl/core/bpfa_map_ram.sv =====
// Synchronous single write, single read bitmap memory with registered read data.
module bpfa_map_ram #(
   parameter int WIDTH  = 64,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [WIDTH-1:0] words_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= words_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bpfa_word_scan.sv =====
// First clear bit search in one bitmap word, bounded by the hint and the page limit.
module bpfa_word_scan #(
   parameter int LANE_BITS = 64
) (
   input  logic [LANE_BITS-1:0]                          word,
   input  logic [bpfa_pkg::IPAGE_W-$clog2(LANE_BITS)-1:0] word_num,
   input  bpfa_pkg::ipage_type                           hint,
   input  bpfa_pkg::ipage_type                           limit,
   output logic                                          found,
   output logic [$clog2(LANE_BITS)-1:0]                  pos,
   output logic [LANE_BITS-1:0]                          onehot
);

   import bpfa_pkg::*;

   localparam int LB_W = $clog2(LANE_BITS);

   logic [LB_W-1:0]      lo_off;
   logic [LB_W-1:0]      hi_off;
   logic                 cut;
   logic [LANE_BITS-1:0] allow;
   logic [LANE_BITS-1:0] cand;

   assign lo_off = (word_num == hint[IPAGE_W-1:LB_W]) ? hint[LB_W-1:0] : '0;
   assign cut    = (word_num == limit[IPAGE_W-1:LB_W]);
   assign hi_off = limit[LB_W-1:0];

   always_comb begin
      for (int b = 0; b < LANE_BITS; b++) begin
         allow[b] = (LB_W'(b) >= lo_off) && (!cut || (LB_W'(b) < hi_off));
      end
   end

   assign cand   = ~word & allow;
   assign onehot = cand & (~cand + 1'b1);
   assign found  = |cand;

   always_comb begin
      pos = '0;
      for (int b = 0; b < LANE_BITS; b++) begin
         pos = pos | (onehot[b] ? LB_W'(b) : '0);
      end
   end

endmodule

// ===== tb/bitmap_page_frame_allocator_core_tb.sv =====
// Self-checking testbench of the bitmap page frame allocator core.
module bitmap_page_frame_allocator_core_tb;
   import bpfa_pkg::*;

   localparam int MAP_PAGES   = 16384;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic [PAGE_W-1:0] page;
      status_type        status;
      count_type         free_cnt;
      count_type         used_cnt;
      count_type         reserved_cnt;
   } alloc_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func = FUNC_REQUEST;
   logic [PAGE_W-1:0]   req_page_index = '0;
   logic                rsp_strobe;
   logic [PAGE_W-1:0]   rsp_result_page;
   logic [STAT_W-1:0]   rsp_status;
   logic [CNT_W-1:0]    rsp_free_pages;
   logic [CNT_W-1:0]    rsp_used_pages;
   logic [CNT_W-1:0]    rsp_reserved_pages;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_W-1:0]    csr_pages_in_use = PAGES_RESET;

   bit                  page_map [MAP_PAGES];
   ipage_type           alloc_hint = '0;
   count_type           used_cnt = '0;
   count_type           reserved_cnt = '0;
   count_type           page_limit = PAGES_RESET;

   alloc_result_type    pending_results [$];
   alloc_result_type    head;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  sender_idle_pct = 0;

   bitmap_page_frame_allocator_core #(
      .NUM_PAGES(MAP_PAGES),
      .WORD_BITS(64)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_page_index(req_page_index),
      .rsp_strobe(rsp_strobe),
      .rsp_result_page(rsp_result_page),
      .rsp_status(rsp_status),
      .rsp_free_pages(rsp_free_pages),
      .rsp_used_pages(rsp_used_pages),
      .rsp_reserved_pages(rsp_reserved_pages),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_pages_in_use(csr_pages_in_use)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic count_type count_up(input count_type c);
      return (c == CNT_MAX) ? c : count_type'(c + 1'b1);
   endfunction

   function automatic count_type count_down(input count_type c);
      return (c == '0) ? c : count_type'(c - 1'b1);
   endfunction

   function automatic alloc_result_type predict_alloc(input logic [FUNC_W-1:0] func,
                                                      input logic [PAGE_W-1:0] idx);
      alloc_result_type r;
      int               limit;
      int               scan;
      int               taken;
      bit               target;
      limit = (page_limit > MAP_PAGES) ? MAP_PAGES : int'(page_limit);
      r.page = idx;
      r.status = STAT_DONE;
      if (func == FUNC_REQUEST) begin
         r.page = '0;
         r.status = STAT_NO_FREE;
         scan = alloc_hint;
         while (scan < limit && page_map[scan]) scan++;
         if (scan < limit) begin
            page_map[scan] = 1'b1;
            used_cnt = count_up(used_cnt);
            r.page = scan[PAGE_W-1:0];
            r.status = STAT_DONE;
         end
         if (alloc_hint < limit) alloc_hint = scan[IPAGE_W-1:0];
      end else if (func > FUNC_UNRESERVE || idx >= limit) begin
         r.status = STAT_RANGE;
      end else begin
         target = (func == FUNC_LOCK || func == FUNC_RESERVE);
         if (page_map[idx] == target) begin
            r.status = STAT_ALREADY;
         end else begin
            page_map[idx] = target;
            case (func)
               FUNC_FREE: used_cnt = count_down(used_cnt);
               FUNC_LOCK: used_cnt = count_up(used_cnt);
               FUNC_RESERVE: reserved_cnt = count_up(reserved_cnt);
               default: reserved_cnt = count_down(reserved_cnt);
            endcase
            if (!target && alloc_hint > idx) alloc_hint = {1'b0, idx};
         end
      end
      taken = int'(used_cnt) + int'(reserved_cnt);
      r.free_cnt = (limit > taken) ? count_type'(limit - taken) : '0;
      r.used_cnt = used_cnt;
      r.reserved_cnt = reserved_cnt;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no operation pending");
            mismatch_count++;
         end else begin
            head = pending_results.pop_front();
            check_field("result_page", 16'(head.page), 16'(rsp_result_page));
            check_field("status", 16'(head.status), 16'(rsp_status));
            check_field("free_pages", 16'(head.free_cnt), 16'(rsp_free_pages));
            check_field("used_pages", 16'(head.used_cnt), 16'(rsp_used_pages));
            check_field("reserved_pages", 16'(head.reserved_cnt),
                        16'(rsp_reserved_pages));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("cycle limit reached");
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic issue_op(input logic [FUNC_W-1:0] func, input logic [PAGE_W-1:0] idx);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      start <= 1'b1;
      req_func <= func;
      req_page_index <= idx;
      do @(posedge clock); while (busy !== 1'b0);
      pending_results.push_back(predict_alloc(func, idx));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_page_limit(input count_type value);
      drain_results();
      csr_valid <= 1'b1;
      csr_pages_in_use <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      page_limit = value;
   endtask

   task automatic test_single_page_ops();
      issue_op(FUNC_REQUEST, '0);
      issue_op(FUNC_REQUEST, '1);
      issue_op(FUNC_FREE, 14'd0);
      issue_op(FUNC_FREE, 14'd0);
      issue_op(FUNC_LOCK, 14'd16383);
      issue_op(FUNC_LOCK, 14'd16383);
      issue_op(FUNC_RESERVE, 14'd0);
      issue_op(FUNC_RESERVE, 14'd0);
      issue_op(FUNC_UNRESERVE, 14'd0);
      issue_op(FUNC_UNRESERVE, 14'd0);
      issue_op(FUNC_FREE, 14'd1);
      issue_op(FUNC_FREE, 14'd16383);
   endtask

   task automatic test_unknown_funcs();
      issue_op(3'd5, 14'd16383);
      issue_op(3'd6, 14'd0);
      issue_op(3'd7, 14'h2AAA);
   endtask

   // Freeing a reserved page clears its bit while the used count stays at zero.
   task automatic test_counter_floor();
      issue_op(FUNC_RESERVE, 14'd7);
      issue_op(FUNC_FREE, 14'd7);
      issue_op(FUNC_UNRESERVE, 14'd7);
   endtask

   task automatic test_pool_exhaustion();
      set_page_limit(count_type'(1));
      issue_op(FUNC_REQUEST, '0);
      issue_op(FUNC_REQUEST, '0);
      issue_op(FUNC_REQUEST, '1);
      issue_op(FUNC_LOCK, 14'd1);
      issue_op(FUNC_FREE, 14'd0);
      issue_op(FUNC_REQUEST, '0);
   endtask

   task automatic test_oversized_limit();
      set_page_limit(CNT_MAX);
      issue_op(FUNC_LOCK, 14'd16383);
      issue_op(FUNC_REQUEST, '0);
   endtask

   task automatic test_random_traffic(input int phase, input int idle_pct);
      int                seg;
      int                n;
      int                lim;
      int                pick;
      logic [FUNC_W-1:0] func;
      logic [PAGE_W-1:0] idx;
      count_type         limit_value;
      sender_idle_pct = idle_pct;
      for (seg = 0; seg < 4; seg++) begin
         case (seg)
            0: limit_value = (phase == 0) ? count_type'(1) : count_type'($urandom_range(2, 8));
            1: limit_value = count_type'($urandom_range(60, 70));
            2: limit_value = count_type'($urandom_range(100, 300));
            default: begin
               if (phase == 0) limit_value = PAGES_RESET;
               else if (phase == 1) limit_value = CNT_MAX;
               else limit_value = count_type'($urandom_range(16385, 32767));
            end
         endcase
         set_page_limit(limit_value);
         lim = (limit_value > MAP_PAGES) ? MAP_PAGES : int'(limit_value);
         for (n = 0; n < 52; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) func = FUNC_REQUEST;
            else if (pick < 58) func = FUNC_FREE;
            else if (pick < 68) func = FUNC_LOCK;
            else if (pick < 81) func = FUNC_RESERVE;
            else if (pick < 95) func = FUNC_UNRESERVE;
            else func = FUNC_W'($urandom_range(5, 7));
            if ($urandom_range(9) == 0) idx = PAGE_W'($urandom);
            else idx = PAGE_W'($urandom_range(lim));
            issue_op(func, idx);
            if ($urandom_range(39) == 0) drain_results();
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 17;
      test_single_page_ops();
      test_unknown_funcs();
      test_counter_floor();
      test_pool_exhaustion();
      test_oversized_limit();
      test_random_traffic(0, 17);
      test_random_traffic(1, 84);
      test_random_traffic(2, 0);
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
